### hw/rtl/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg: shared types and constants for the schoolbook multiplier
// Word widths, field widths, input mode codes, sequencer states and the
// control/result bundles between the top level and the MAC unit.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int WORD_W = 32;  // limb width
  localparam int WC_W   = 6;   // word_count register width
  localparam int IDX_W  = 5;   // word_index field width
  localparam int POS_W  = 6;   // word_position field width

  localparam logic [WC_W-1:0] WC_RESET = 6'd32;

  // Input item modes
  localparam logic MODE_LOAD = 1'b0;  // store one first-operand word
  localparam logic MODE_ROW  = 1'b1;  // apply next second-operand word

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_CARRY,
    ST_EMIT_LOW,
    ST_HIGH_RD,
    ST_HIGH_OUT
  } state_e;

  // Control into the MAC unit
  typedef struct packed {
    logic clear;     // new row: clear the running carry
    logic valid;     // stage-1 operands are valid this cycle
    logic zero_acc;  // row 0: accumulator reads as zero
  } mac_ctrl_t;

  // Result out of the MAC unit
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] sum_lo;
  } mac_res_t;

endpackage

### hw/rtl/smm_ifs.sv
// ----------------------------------------------------------------------------
// smm channel interfaces
// Valid/ready channels for input items, product words and the word count
// register write.
// ----------------------------------------------------------------------------
interface smm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [smm_pkg::IDX_W-1:0]  word_index;
  logic [smm_pkg::WORD_W-1:0] word;

  modport source (output valid, mode, word_index, word, input ready);
  modport sink   (input valid, mode, word_index, word, output ready);
endinterface

interface smm_out_if;
  logic                       valid;
  logic                       ready;
  logic [smm_pkg::WORD_W-1:0] product_word;
  logic [smm_pkg::POS_W-1:0]  word_position;
  logic                       last_word;

  modport source (output valid, product_word, word_position, last_word, input ready);
  modport sink   (input valid, product_word, word_position, last_word, output ready);
endinterface

interface smm_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [smm_pkg::WC_W-1:0] word_count;

  modport source (output valid, word_count, input ready);
  modport sink   (input valid, word_count, output ready);
endinterface

### hw/rtl/smm_mac_unit.sv
// ----------------------------------------------------------------------------
// smm_mac_unit: shared multiply-accumulate unit
// Two stages: registered 32x32 product, then product + accumulator word +
// running carry. The high half of each sum becomes the next carry.
// ----------------------------------------------------------------------------
module smm_mac_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smm_pkg::mac_ctrl_t         ctrl_i,
  input  logic [smm_pkg::WORD_W-1:0] a_i,      // first-operand word
  input  logic [smm_pkg::WORD_W-1:0] p_i,      // accumulator word
  input  logic [smm_pkg::WORD_W-1:0] w_i,      // second-operand word
  output smm_pkg::mac_res_t          res_o,
  output logic [smm_pkg::WORD_W-1:0] carry_o
);

  localparam int W = smm_pkg::WORD_W;

  logic            v2_q;
  logic [2*W-1:0]  prod_q;
  logic [W-1:0]    p2_q;
  logic [W-1:0]    carry_q;
  logic [2*W-1:0]  sum;

  // Multiply stage
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * w_i;
    p2_q   <= ctrl_i.zero_acc ? '0 : p_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      carry_q <= '0;
    end else begin
      v2_q <= ctrl_i.valid;
      if (ctrl_i.clear) begin
        carry_q <= '0;
      end else if (v2_q) begin
        carry_q <= sum[2*W-1:W];
      end
    end
  end

  // Accumulate stage: max value is 2^64-1, no overflow
  assign sum = prod_q + {{W{1'b0}}, p2_q} + {{W{1'b0}}, carry_q};

  assign res_o.valid  = v2_q;
  assign res_o.sum_lo = sum[W-1:0];
  assign carry_o      = carry_q;

endmodule

### hw/rtl/schoolbook_multiword_multiply_top.sv
// ----------------------------------------------------------------------------
// schoolbook_multiword_multiply_top: multiword multiplier, 32-bit limbs
// Schoolbook product of two n-word numbers, one row per second-operand word.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i writes word_count (n, clamped to 1..MAX_WORDS); the write also
//   restarts the product at row 0. It is taken only while the block is idle.
//   in_i mode 0 stores one first-operand word at word_index.
//   in_i mode 1 brings second-operand word i (rows in order from 0). Each row
//   runs n multiply-accumulate steps through the one 32x32 multiplier and
//   emits product word i on out_o; the last row also emits words n..2n-1,
//   the top one with last_word set.
// Timing: the shared MAC unit issues one step per cycle through its two-stage
//   pipeline, then the row's carry is written. The last row then reads each
//   high word from registered memory and passes it to the output register.
//   in_i is not ready while a row is in flight.
// Stall: out_o is a single output register; the sequencer waits while it is
//   full and not taken, then resumes with no loss.
// Reset: word_count returns to 32, row counter to 0, no transaction is held.
//   Operand and accumulator memories are not cleared.
// ----------------------------------------------------------------------------
module schoolbook_multiword_multiply_top #(
  parameter int MAX_WORDS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smm_in_if.sink    in_i,
  smm_out_if.source out_o,
  smm_cfg_if.sink   cfg_i
);

  localparam int W  = smm_pkg::WORD_W;
  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int PW = $clog2(2 * MAX_WORDS);

  // Operand and accumulator memories
  logic [W-1:0] a_mem [MAX_WORDS];
  logic [W-1:0] p_mem [2*MAX_WORDS];
  logic [W-1:0] a_rd_q;
  logic [W-1:0] p_rd_q;

  smm_pkg::state_e state_q, state_d;

  logic [smm_pkg::WC_W-1:0] wc_q;
  logic [CW-1:0]            row_q;
  logic [CW-1:0]            i_q;
  logic [CW-1:0]            j_q;
  logic [CW-1:0]            j1_q;
  logic [CW-1:0]            j2_q;
  logic                     v1_q;
  logic [W-1:0]             w_q;
  logic [W-1:0]             low_q;
  logic [PW-1:0]            k_q;

  logic                      out_valid_q;
  logic [W-1:0]              out_word_q;
  logic [smm_pkg::POS_W-1:0] out_pos_q;
  logic                      out_last_q;

  logic [CW-1:0] n;
  logic [CW-1:0] row_start;
  logic [PW-1:0] last_pos;
  logic          in_acc;
  logic          cfg_acc;
  logic          out_free;
  logic          issue;
  logic          emit_low;
  logic          emit_high;
  logic          p_we;
  logic [PW-1:0] p_waddr;
  logic [W-1:0]  p_wdata;
  logic [PW-1:0] p_raddr;

  smm_pkg::mac_ctrl_t mac_ctrl;
  smm_pkg::mac_res_t  mac_res;
  logic [W-1:0]       mac_carry;

  // Working size, clamped
  always_comb begin
    if (wc_q == '0) begin
      n = CW'(1);
    end else if (7'(wc_q) > 7'(MAX_WORDS)) begin
      n = CW'(MAX_WORDS);
    end else begin
      n = CW'(wc_q);
    end
  end

  assign row_start = (row_q >= n) ? '0 : row_q;
  assign last_pos  = PW'({n, 1'b0}) - PW'(1);

  // Handshakes
  assign in_i.ready  = (state_q == smm_pkg::ST_IDLE);
  assign cfg_i.ready = (state_q == smm_pkg::ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    issue     = 1'b0;
    emit_low  = 1'b0;
    emit_high = 1'b0;
    case (state_q)
      smm_pkg::ST_IDLE: begin
        if (in_acc && in_i.mode == smm_pkg::MODE_ROW) begin
          state_d = smm_pkg::ST_MAC;
        end
      end
      smm_pkg::ST_MAC: begin
        if (j_q != n) begin
          issue = 1'b1;
        end else if (!v1_q && !mac_res.valid) begin
          state_d = smm_pkg::ST_CARRY;
        end
      end
      smm_pkg::ST_CARRY: begin
        state_d = smm_pkg::ST_EMIT_LOW;
      end
      smm_pkg::ST_EMIT_LOW: begin
        if (out_free) begin
          emit_low = 1'b1;
          state_d  = (i_q == n - CW'(1)) ? smm_pkg::ST_HIGH_RD : smm_pkg::ST_IDLE;
        end
      end
      smm_pkg::ST_HIGH_RD: begin
        state_d = smm_pkg::ST_HIGH_OUT;
      end
      smm_pkg::ST_HIGH_OUT: begin
        if (out_free) begin
          emit_high = 1'b1;
          state_d   = (k_q == last_pos) ? smm_pkg::ST_IDLE : smm_pkg::ST_HIGH_RD;
        end
      end
      default: begin
        state_d = smm_pkg::ST_IDLE;
      end
    endcase
  end

  // Accumulator write port: MAC result or the row's final carry
  always_comb begin
    p_we    = 1'b0;
    p_waddr = PW'(i_q) + PW'(j2_q);
    p_wdata = mac_res.sum_lo;
    if (mac_res.valid) begin
      p_we = 1'b1;
    end else if (state_q == smm_pkg::ST_CARRY) begin
      p_we    = 1'b1;
      p_waddr = PW'(i_q) + PW'(n);
      p_wdata = mac_carry;
    end
  end

  assign p_raddr = (state_q == smm_pkg::ST_HIGH_RD || state_q == smm_pkg::ST_HIGH_OUT)
                   ? k_q : PW'(i_q) + PW'(j_q);

  // Memories
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.mode == smm_pkg::MODE_LOAD &&
        7'(in_i.word_index) < 7'(MAX_WORDS)) begin
      a_mem[AW'(in_i.word_index)] <= in_i.word;
    end
    a_rd_q <= a_mem[AW'(j_q)];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      p_mem[p_waddr] <= p_wdata;
    end
    p_rd_q <= p_mem[p_raddr];
  end

  // Shared MAC unit
  assign mac_ctrl.clear    = in_acc && in_i.mode == smm_pkg::MODE_ROW;
  assign mac_ctrl.valid    = v1_q;
  assign mac_ctrl.zero_acc = (i_q == '0);

  smm_mac_unit u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .a_i     (a_rd_q),
    .p_i     (p_rd_q),
    .w_i     (w_q),
    .res_o   (mac_res),
    .carry_o (mac_carry)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smm_pkg::ST_IDLE;
      wc_q        <= smm_pkg::WC_RESET;
      row_q       <= '0;
      j_q         <= '0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      if (cfg_acc) begin
        wc_q  <= cfg_i.word_count;
        row_q <= '0;
      end
      if (in_acc && in_i.mode == smm_pkg::MODE_ROW) begin
        j_q <= '0;
      end else if (issue) begin
        j_q <= j_q + CW'(1);
      end
      if (emit_low) begin
        row_q <= (i_q == n - CW'(1)) ? '0 : i_q + CW'(1);
      end
      if (emit_low || emit_high) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    j1_q <= j_q;
    j2_q <= j1_q;
    if (in_acc && in_i.mode == smm_pkg::MODE_ROW) begin
      i_q <= row_start;
      w_q <= in_i.word;
    end
    // product word i is settled by the row's first step
    if (mac_res.valid && j2_q == '0) begin
      low_q <= mac_res.sum_lo;
    end
    if (emit_low) begin
      k_q        <= PW'(n);
      out_word_q <= low_q;
      out_pos_q  <= smm_pkg::POS_W'(i_q);
      out_last_q <= 1'b0;
    end else if (emit_high) begin
      k_q        <= k_q + PW'(1);
      out_word_q <= p_rd_q;
      out_pos_q  <= smm_pkg::POS_W'(k_q);
      out_last_q <= (k_q == last_pos);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.product_word  = out_word_q;
  assign out_o.word_position = out_pos_q;
  assign out_o.last_word     = out_last_q;

  // Checks
  a_ready_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!v1_q && !mac_res.valid))
    else $error("input ready while MAC pipeline busy");

  a_carry_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smm_pkg::ST_CARRY) |-> (!v1_q && !mac_res.valid && j_q == n))
    else $error("carry written before row finished");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smm_pkg::ST_MAC) |-> (j_q <= n))
    else $error("issue counter ran past word count");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q < n))
    else $error("row counter out of range");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: schoolbook multiword multiplier
// Drives first-operand loads and second-operand rows through the valid/ready
// channels. A shadow copy of the operand store, the accumulator and the row
// counter predicts every product word, and each product word is checked in
// order. Phases cover several word counts and idle/stall mixes, plus one long
// output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WORDS    = 32;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int SETTLE_CYC   = 2 * MAX_WORDS + 40;  // last row plus high words
  localparam int HOLD_LEN     = 400;
  localparam int MAX_REPORTS  = 60;

  typedef struct packed {
    logic                       mode;
    logic [smm_pkg::IDX_W-1:0]  index;
    logic [smm_pkg::WORD_W-1:0] word;
  } operand_item_t;

  typedef struct packed {
    logic [smm_pkg::WORD_W-1:0] word;
    logic [smm_pkg::POS_W-1:0]  position;
    logic                       last;
  } product_word_t;

  logic clk_i;
  logic rst_ni;

  smm_in_if  in_ch();
  smm_out_if out_ch();
  smm_cfg_if cfg_ch();

  schoolbook_multiword_multiply_top #(.MAX_WORDS(MAX_WORDS)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Stimulus feed and expected product words
  operand_item_t operand_feed[$];
  product_word_t awaited_words[$];

  // Shadow state of the multiplier
  logic [smm_pkg::WORD_W-1:0] first_words [MAX_WORDS];
  logic [smm_pkg::WORD_W-1:0] accum_words [2*MAX_WORDS];
  int unsigned                next_row;
  logic [smm_pkg::WC_W-1:0]   word_count_shadow;

  // Generator bookkeeping
  logic [MAX_WORDS-1:0] loaded_mask;
  int unsigned          items_queued;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        in_fire;

  logic        hold_arm;
  logic        hold_done;
  int unsigned hold_cnt;
  wire         hold_busy = hold_arm && !hold_done;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Working size: 0 acts as 1, anything above the store size is clipped
  function automatic int unsigned clamp_words(input logic [smm_pkg::WC_W-1:0] wc);
    if (wc == 0) return 1;
    if (wc > MAX_WORDS) return MAX_WORDS;
    return 32'(wc);
  endfunction

  // Shadow update for one accepted operand transaction
  function automatic void apply_operand_word(input operand_item_t it);
    int unsigned n;
    int unsigned row;
    int unsigned j;
    logic [63:0] acc;
    logic [smm_pkg::WORD_W-1:0] carry;
    product_word_t pw;
    n = clamp_words(word_count_shadow);
    if (it.mode == smm_pkg::MODE_LOAD) begin
      first_words[it.index] = it.word;
      return;
    end
    row = next_row;
    if (row >= n) row = 0;
    carry = '0;
    for (j = 0; j < n; j++) begin
      acc = ((row == 0) ? 64'd0 : {32'd0, accum_words[row+j]})
          + {32'd0, first_words[j]} * {32'd0, it.word}
          + {32'd0, carry};
      accum_words[row+j] = acc[31:0];
      carry = acc[63:32];
    end
    accum_words[row+n] = carry;
    pw.word = accum_words[row];
    pw.position = row[smm_pkg::POS_W-1:0];
    pw.last = 1'b0;
    awaited_words.push_back(pw);
    // last row flushes the upper half
    if (row == n - 1) begin
      for (j = n; j < 2 * n; j++) begin
        pw.word = accum_words[j];
        pw.position = j[smm_pkg::POS_W-1:0];
        pw.last = (j == 2 * n - 1);
        awaited_words.push_back(pw);
      end
      next_row = 0;
    end else begin
      next_row = row + 1;
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Monitor: predictions on accepted inputs, checks on accepted product words
  always @(posedge clk_i) begin : monitor
    product_word_t exp_w;
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        word_count_shadow = cfg_ch.word_count;
        next_row = 0;
      end
      if (in_ch.valid && in_ch.ready)
        apply_operand_word({in_ch.mode, in_ch.word_index, in_ch.word});
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch($sformatf("unexpected product word %h at position %0d",
                                    out_ch.product_word, out_ch.word_position));
        end else begin
          exp_w = awaited_words.pop_front();
          if (out_ch.product_word !== exp_w.word)
            report_mismatch($sformatf("product_word %h, expected %h (position %0d)",
                                      out_ch.product_word, exp_w.word, exp_w.position));
          if (out_ch.word_position !== exp_w.position)
            report_mismatch($sformatf("word_position %0d, expected %0d",
                                      out_ch.word_position, exp_w.position));
          if (out_ch.last_word !== exp_w.last)
            report_mismatch($sformatf("last_word %b, expected %b (position %0d)",
                                      out_ch.last_word, exp_w.last, exp_w.position));
        end
      end
    end
  end

  // Operand driver: next transaction once the current one is taken
  always @(negedge clk_i) begin : operand_driver
    operand_item_t nxt;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (operand_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = operand_feed.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= nxt.mode;
        in_ch.word_index <= nxt.index;
        in_ch.word       <= nxt.word;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Product receiver with random stalls
  always @(negedge clk_i) begin
    out_ch.ready <= rst_ni && !hold_busy && ($urandom_range(99) >= stall_pct);
  end

  // Long output hold-off, counted here
  always @(negedge clk_i) begin
    if (hold_busy) begin
      if (hold_cnt >= HOLD_LEN) hold_done <= 1'b1;
      else hold_cnt <= hold_cnt + 1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d product words pending",
               cycle_count, awaited_words.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic logic [smm_pkg::WORD_W-1:0] rand_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000 | $urandom;
      3:       return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_load(input int unsigned idx, input logic [smm_pkg::WORD_W-1:0] w);
    operand_feed.push_back({smm_pkg::MODE_LOAD, idx[smm_pkg::IDX_W-1:0], w});
    loaded_mask[idx] = 1'b1;
    items_queued++;
  endtask

  // index field is don't-care for rows, so randomize it
  task automatic push_row(input logic [smm_pkg::WORD_W-1:0] w);
    logic [31:0]               rnd;
    logic [smm_pkg::IDX_W-1:0] junk;
    rnd  = $urandom;
    junk = rnd[smm_pkg::IDX_W-1:0];
    operand_feed.push_back({smm_pkg::MODE_ROW, junk, w});
    items_queued++;
  endtask

  // One product (or its first rows): defined first-operand words, then rows
  // with occasional loads slipped in between rows
  task automatic queue_product(input int unsigned n, input int unsigned rows);
    int unsigned j;
    for (j = 0; j < n; j++)
      if (!loaded_mask[j] || $urandom_range(3) == 0) push_load(j, rand_word());
    for (j = 0; j < rows; j++) begin
      if ($urandom_range(7) == 0) push_load($urandom_range(MAX_WORDS - 1), rand_word());
      push_row(rand_word());
    end
  endtask

  task automatic wait_drain();
    while (operand_feed.size() != 0 || in_ch.valid || awaited_words.size() != 0)
      @(posedge clk_i);
  endtask

  // Quiesce, write word_count, set the idle mix for the next phase
  task automatic begin_phase(input logic [smm_pkg::WC_W-1:0] wc,
                             input int unsigned send_pct, input int unsigned out_pct);
    wait_drain();
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.word_count <= wc;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid  <= 1'b0;
    send_idle_pct = send_pct;
    stall_pct     = out_pct;
  endtask

  task automatic random_phase(input logic [smm_pkg::WC_W-1:0] wc,
                              input int unsigned send_pct,
                              input int unsigned out_pct, input int unsigned budget,
                              input bit pressure);
    int unsigned n;
    int unsigned start;
    begin_phase(wc, send_pct, out_pct);
    n = clamp_words(wc);
    start = items_queued;
    while (items_queued - start < budget) queue_product(n, n);
    // leave a product unfinished now and then; the next write restarts it
    if (n > 1 && $urandom_range(1) == 1) queue_product(n, $urandom_range(1, n - 1));
    if (pressure) hold_arm = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = smm_pkg::MODE_LOAD;
    in_ch.word_index = '0;
    in_ch.word = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.word_count = smm_pkg::WC_RESET;
    in_fire = 1'b0;
    hold_arm = 1'b0;
    hold_done = 1'b0;
    hold_cnt = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    cycle_count = 0;
    loaded_mask = '0;
    items_queued = 0;
    next_row = 0;
    word_count_shadow = smm_pkg::WC_RESET;
    foreach (first_words[k]) first_words[k] = '0;
    foreach (accum_words[k]) accum_words[k] = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero count acts as one word
    begin_phase(6'd0, 0, 0);
    push_load(0, 32'hFFFF_FFFF);
    push_load(31, 32'h1234_5678);  // beyond n: stored, not used
    push_row(32'hFFFF_FFFF);
    push_row(32'h0000_0000);
    push_row(32'h0000_0001);
    push_load(0, 32'h0000_0000);
    push_row(32'hFFFF_FFFF);

    // Directed: two words, all-ones square, mid-product load, unfinished product
    begin_phase(6'd2, 0, 0);
    push_load(0, 32'hFFFF_FFFF);
    push_load(1, 32'hFFFF_FFFF);
    push_row(32'hFFFF_FFFF);
    push_row(32'hFFFF_FFFF);
    push_load(0, 32'h8000_0000);
    push_row(32'h0000_0001);
    push_load(1, 32'h0000_0000);
    push_row(32'h8000_0000);
    push_load(1, 32'h5555_AAAA);
    push_row(32'hAAAA_5555);
    push_row(32'h0000_0000);
    push_row(32'hFFFF_FFFF);

    // Random phases
    random_phase(6'd32, 0,  0,  64, 1'b0);
    random_phase(6'd3,  0,  0,  40, 1'b0);
    random_phase(6'd5,  86, 0,  40, 1'b0);
    random_phase(6'd1,  0,  86, 30, 1'b0);
    random_phase(6'd7,  16, 16, 40, 1'b0);
    random_phase(6'd63, 16, 16, 40, 1'b0);
    random_phase(6'd4,  0,  0,  40, 1'b1);
    random_phase(6'd33, 0,  86, 33, 1'b0);

    wait_drain();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_words.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/smm_pkg.sv
hw/rtl/smm_ifs.sv
hw/rtl/smm_mac_unit.sv
hw/rtl/schoolbook_multiword_multiply_top.sv
tb/testbench.sv
